[src/bese_pkg.sv]
// shared types, constants and tables for the battery energy monitor
`timescale 1ns / 1ps

package bese_pkg;

    // field widths
    localparam int CMD_W      = 2;
    localparam int BUS_W      = 15;
    localparam int CUR_W      = 16;
    localparam int TEMP_W     = 12;
    localparam int TS_W       = 32;
    localparam int POWER_W    = 22;
    localparam int ENERGY_W   = 33;
    localparam int SOC_W      = 10;
    localparam int FCODE_W    = 2;
    localparam int CELL_W     = 4;
    localparam int CUTOFF_W   = 13;
    localparam int IMAX_W     = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam int IN_TDATA_W    = 80;
    localparam int OUT_FIELDS_W  = POWER_W + ENERGY_W + SOC_W + 1 + FCODE_W;
    localparam int OUT_TDATA_W   = 72;
    localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_FIELDS_W;

    // datapath widths
    localparam int ACC_W     = 64;
    localparam int DIVR_W    = 32;
    localparam int MUL_W     = 32;
    localparam int PMAG_W    = 30;
    localparam int VOLT_W    = 13;
    localparam int PCT_W     = 7;
    localparam int VN_W      = VOLT_W + CELL_W;
    localparam int DPCT_W    = PCT_W + CELL_W;
    localparam int DIV_CNT_W = 6;

    // soc table
    localparam int SOC_POINTS = 10;
    localparam int SOC_IW     = $clog2(SOC_POINTS);

    // arithmetic constants
    localparam logic [DIVR_W-1:0]    POWER_DIV        = 32'd1000;
    localparam logic [DIVR_W-1:0]    ENERGY_DIV       = 32'd3600000000;
    localparam logic [CELL_W-1:0]    PCT_SCALE        = 4'd10;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_WIDE   = 6'd32;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_NARROW = 6'd16;
    localparam logic [ACC_W-1:0]     ACC_MAX          = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0]     ACC_MIN          = {1'b1, {(ACC_W-1){1'b0}}};

    // command codes
    localparam logic [CMD_W-1:0] CMD_SAMPLE      = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SESSION_RST = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FAULT_CLR   = 2'd2;

    // fault codes
    localparam logic [FCODE_W-1:0] FLT_NONE      = 2'd0;
    localparam logic [FCODE_W-1:0] FLT_OVER_VOLT = 2'd1;
    localparam logic [FCODE_W-1:0] FLT_OVER_TEMP = 2'd2;
    localparam logic [FCODE_W-1:0] FLT_OVER_CUR  = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_CUTOFF = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_CUTOFF = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_MAX = 2'd3;

    // register reset values
    localparam logic [CELL_W-1:0]   CELL_COUNT_RST  = 4'd3;
    localparam logic [CUTOFF_W-1:0] CELL_CUTOFF_RST = 13'd4250;
    localparam logic [TEMP_W-1:0]   TEMP_CUTOFF_RST = 12'd960;
    localparam logic [IMAX_W-1:0]   CURRENT_MAX_RST = 15'd400;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CMD,
        ST_MUL_P,
        ST_MUL_E,
        ST_ACC,
        ST_PDIV,
        ST_EDIV_GO,
        ST_EDIV,
        ST_SOC_FIRST,
        ST_SOC_LAST,
        ST_SOC_SRCH,
        ST_SOC_MUL,
        ST_SOC_DIV_GO,
        ST_SOC_DIV,
        ST_FAULT,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        MUL_POWER,
        MUL_ENERGY,
        MUL_SOC
    } t_mul_sel;

    typedef enum logic [1:0] {
        DIV_POWER,
        DIV_ENERGY,
        DIV_SOC
    } t_div_sel;

    typedef struct packed {
        logic     in_ready;
        logic     load_in;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     acc_upd;
        logic     sess_rst;
        logic     flt_clr;
        logic     div_start;
        t_div_sel div_sel;
        logic     power_wr;
        logic     energy_wr;
        logic     seg_last;
        logic     seg_mid;
        logic     seg_inc;
        logic     soc_const_wr;
        logic     soc_div_wr;
        logic     flt_chk;
        logic     out_wr;
    } t_ctrl;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             div_busy;
        logic             seg_le;
        logic             seg_ge;
        logic             out_busy;
    } t_stat;

    function automatic logic [VOLT_W-1:0] soc_volt_mv(input logic [SOC_IW-1:0] idx);
        logic [VOLT_W-1:0] v;
        unique case (idx)
            4'd0:    v = 13'd3000;
            4'd1:    v = 13'd3200;
            4'd2:    v = 13'd3400;
            4'd3:    v = 13'd3600;
            4'd4:    v = 13'd3700;
            4'd5:    v = 13'd3800;
            4'd6:    v = 13'd3900;
            4'd7:    v = 13'd4000;
            4'd8:    v = 13'd4100;
            4'd9:    v = 13'd4200;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [PCT_W-1:0] soc_pct(input logic [SOC_IW-1:0] idx);
        logic [PCT_W-1:0] p;
        unique case (idx)
            4'd0:    p = 7'd0;
            4'd1:    p = 7'd5;
            4'd2:    p = 7'd10;
            4'd3:    p = 7'd30;
            4'd4:    p = 7'd50;
            4'd5:    p = 7'd70;
            4'd6:    p = 7'd85;
            4'd7:    p = 7'd93;
            4'd8:    p = 7'd98;
            4'd9:    p = 7'd100;
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

[src/bese_div.sv]
// shared unsigned divider, two quotient bits per cycle
`timescale 1ns / 1ps

module bese_div
    import bese_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_wide,
    input  logic [ACC_W-1:0]  i_dividend,
    input  logic [DIVR_W-1:0] i_divisor,
    output logic              o_busy,
    output logic [ACC_W-1:0]  o_quotient
);

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIVR_W-1:0]    r_rem;
    logic [DIVR_W-1:0]    r_div;
    logic [ACC_W-1:0]     r_quo;

    logic [DIVR_W:0]   w_s1;
    logic [DIVR_W:0]   w_s2;
    logic              w_ge1;
    logic              w_ge2;
    logic [DIVR_W-1:0] w_r1;
    logic [DIVR_W-1:0] w_r2;

    always_comb begin
        w_s1  = {r_rem, r_quo[ACC_W-1]};
        w_ge1 = w_s1 >= {1'b0, r_div};
        w_r1  = w_ge1 ? DIVR_W'(w_s1 - {1'b0, r_div}) : w_s1[DIVR_W-1:0];
        w_s2  = {w_r1, r_quo[ACC_W-2]};
        w_ge2 = w_s2 >= {1'b0, r_div};
        w_r2  = w_ge2 ? DIVR_W'(w_s2 - {1'b0, r_div}) : w_s2[DIVR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_wide ? DIV_STEPS_WIDE : DIV_STEPS_NARROW;
        end else if (r_busy) begin
            r_cnt <= r_cnt - DIV_CNT_W'(1);
            if (r_cnt == DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_wide ? i_dividend
                            : {i_dividend[ACC_W-DIVR_W-1:0], {DIVR_W{1'b0}}};
        end else if (r_busy) begin
            r_rem <= w_r2;
            r_quo <= {r_quo[ACC_W-3:0], w_ge1, w_ge2};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

[src/bese_dp.sv]
// datapath: input and config registers, multiplier, accumulator, soc and fault logic
`timescale 1ns / 1ps

module bese_dp
    import bese_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ctrl                 i_ctrl,
    output t_stat                 o_stat,
    input  logic [CMD_W-1:0]      i_command,
    input  logic [BUS_W-1:0]      i_bus_voltage_mv,
    input  logic [CUR_W-1:0]      i_current_ma,
    input  logic [TEMP_W-1:0]     i_cell_temp,
    input  logic [TS_W-1:0]       i_timestamp_ms,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [POWER_W-1:0]    o_power_mw,
    output logic [ENERGY_W-1:0]   o_energy_mwh,
    output logic [SOC_W-1:0]      o_soc_permille,
    output logic                  o_fault_active,
    output logic [FCODE_W-1:0]    o_fault_code
);

    // config
    logic [CELL_W-1:0]   r_cell_count;
    logic [CUTOFF_W-1:0] r_cell_cutoff;
    logic [TEMP_W-1:0]   r_temp_cutoff;
    logic [IMAX_W-1:0]   r_current_max;

    // session state
    logic [ACC_W-1:0]   r_acc;
    logic [TS_W-1:0]    r_last;
    logic               r_flt;
    logic [FCODE_W-1:0] r_reason;
    logic [CMD_W-1:0]   r_cmd;
    logic               r_out_valid;

    // item payload
    logic [BUS_W-1:0]    r_bus;
    logic [CUR_W-1:0]    r_cur;
    logic [TEMP_W-1:0]   r_temp;
    logic [TS_W-1:0]     r_now;
    logic [ACC_W-1:0]    r_prod;
    logic [PMAG_W-1:0]   r_pmag;
    logic [SOC_IW-1:0]   r_seg;
    logic [POWER_W-1:0]  r_power;
    logic [ENERGY_W-1:0] r_energy;
    logic [SOC_W-1:0]    r_soc;
    logic [POWER_W-1:0]  r_o_power;
    logic [ENERGY_W-1:0] r_o_energy;
    logic [SOC_W-1:0]    r_o_soc;
    logic                r_o_flt;
    logic [FCODE_W-1:0]  r_o_code;

    logic [CELL_W-1:0]   w_n;
    logic [VN_W-1:0]     w_bus_x;
    logic [SOC_IW-1:0]   w_seg_m1;
    logic [VN_W-1:0]     w_vn_cur;
    logic [VN_W-1:0]     w_vn_prev;
    logic [VOLT_W-1:0]   w_dv;
    logic [VN_W-1:0]     w_den;
    logic [PCT_W-1:0]    w_dpct;
    logic [DPCT_W-1:0]   w_dpct10;
    logic [SOC_W-1:0]    w_soc_cur;
    logic [SOC_W-1:0]    w_soc_prev;
    logic [CUR_W:0]      w_cur_ext;
    logic [CUR_W:0]      w_cur_mag;
    logic                w_neg;
    logic [MUL_W-1:0]    w_mul_a;
    logic [MUL_W-1:0]    w_mul_b;
    logic [ACC_W-1:0]    w_mul_p;
    logic [ACC_W-1:0]    w_d;
    logic [ACC_W:0]      w_sum;
    logic [ACC_W-1:0]    w_acc_sat;
    logic [ACC_W-1:0]    w_acc_mag;
    logic [ACC_W-1:0]    w_div_num;
    logic [DIVR_W-1:0]   w_div_den;
    logic                w_div_wide;
    logic                w_div_busy;
    logic [ACC_W-1:0]    w_quo;
    logic [POWER_W-1:0]  w_pq;
    logic [ENERGY_W-1:0] w_eq;
    logic [VN_W-1:0]     w_ov_lim;
    logic                w_ov;
    logic                w_ot;
    logic                w_oc;

    // soc segment arithmetic
    assign w_n        = (r_cell_count == '0) ? CELL_W'(1) : r_cell_count;
    assign w_bus_x    = VN_W'(r_bus);
    assign w_seg_m1   = r_seg - SOC_IW'(1);
    assign w_vn_cur   = VN_W'(soc_volt_mv(r_seg)) * VN_W'(w_n);
    assign w_vn_prev  = VN_W'(soc_volt_mv(w_seg_m1)) * VN_W'(w_n);
    assign w_dv       = soc_volt_mv(r_seg) - soc_volt_mv(w_seg_m1);
    assign w_den      = VN_W'(w_dv) * VN_W'(w_n);
    assign w_dpct     = soc_pct(r_seg) - soc_pct(w_seg_m1);
    assign w_dpct10   = DPCT_W'(w_dpct) * DPCT_W'(PCT_SCALE);
    assign w_soc_cur  = SOC_W'(soc_pct(r_seg)) * SOC_W'(PCT_SCALE);
    assign w_soc_prev = SOC_W'(soc_pct(w_seg_m1)) * SOC_W'(PCT_SCALE);

    // current magnitude and sign
    assign w_neg     = r_cur[CUR_W-1];
    assign w_cur_ext = {r_cur[CUR_W-1], r_cur};
    assign w_cur_mag = w_neg ? ((CUR_W+1)'(0) - w_cur_ext) : w_cur_ext;

    // shared multiplier
    always_comb begin
        unique case (i_ctrl.mul_sel)
            MUL_POWER: begin
                w_mul_a = MUL_W'(r_bus);
                w_mul_b = MUL_W'(w_cur_mag);
            end
            MUL_ENERGY: begin
                w_mul_a = MUL_W'(r_prod[PMAG_W-1:0]);
                w_mul_b = r_now - r_last;
            end
            MUL_SOC: begin
                w_mul_a = MUL_W'(w_bus_x - w_vn_prev);
                w_mul_b = MUL_W'(w_dpct10);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul_p = ACC_W'(w_mul_a) * ACC_W'(w_mul_b);

    // saturating accumulate
    assign w_d       = w_neg ? (ACC_W'(0) - r_prod) : r_prod;
    assign w_sum     = {r_acc[ACC_W-1], r_acc} + {w_d[ACC_W-1], w_d};
    assign w_acc_sat = (w_sum[ACC_W] != w_sum[ACC_W-1]) ?
                       (w_sum[ACC_W] ? ACC_MIN : ACC_MAX) : w_sum[ACC_W-1:0];
    assign w_acc_mag = r_acc[ACC_W-1] ? (ACC_W'(0) - r_acc) : r_acc;

    // divider operands
    always_comb begin
        unique case (i_ctrl.div_sel)
            DIV_POWER: begin
                w_div_num  = ACC_W'(r_pmag);
                w_div_den  = POWER_DIV;
                w_div_wide = 1'b0;
            end
            DIV_ENERGY: begin
                w_div_num  = w_acc_mag;
                w_div_den  = ENERGY_DIV;
                w_div_wide = 1'b1;
            end
            DIV_SOC: begin
                w_div_num  = r_prod;
                w_div_den  = DIVR_W'(w_den);
                w_div_wide = 1'b0;
            end
            default: begin
                w_div_num  = '0;
                w_div_den  = POWER_DIV;
                w_div_wide = 1'b0;
            end
        endcase
    end

    bese_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_ctrl.div_start),
        .i_wide     (w_div_wide),
        .i_dividend (w_div_num),
        .i_divisor  (w_div_den),
        .o_busy     (w_div_busy),
        .o_quotient (w_quo)
    );

    assign w_pq = w_quo[POWER_W-1:0];
    assign w_eq = w_quo[ENERGY_W-1:0];

    // fault checks in priority order
    assign w_ov_lim = VN_W'(r_cell_cutoff) * VN_W'(w_n);
    assign w_ov     = w_bus_x > w_ov_lim;
    assign w_ot     = $signed(r_temp) > $signed(r_temp_cutoff);
    assign w_oc     = $signed(r_cur) > $signed({1'b0, r_current_max});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_count  <= CELL_COUNT_RST;
            r_cell_cutoff <= CELL_CUTOFF_RST;
            r_temp_cutoff <= TEMP_CUTOFF_RST;
            r_current_max <= CURRENT_MAX_RST;
            r_acc         <= '0;
            r_last        <= '0;
            r_flt         <= 1'b0;
            r_reason      <= FLT_NONE;
            r_cmd         <= CMD_SAMPLE;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_CELL_COUNT:  r_cell_count  <= i_cfg_data[CELL_W-1:0];
                    CFG_CELL_CUTOFF: r_cell_cutoff <= i_cfg_data[CUTOFF_W-1:0];
                    CFG_TEMP_CUTOFF: r_temp_cutoff <= i_cfg_data[TEMP_W-1:0];
                    CFG_CURRENT_MAX: r_current_max <= i_cfg_data[IMAX_W-1:0];
                    default:         r_current_max <= r_current_max;
                endcase
            end
            if (i_ctrl.load_in) begin
                r_cmd <= i_command;
            end
            if (i_ctrl.acc_upd) begin
                if (r_last != '0) begin
                    r_acc <= w_acc_sat;
                end
                r_last <= r_now;
            end
            if (i_ctrl.sess_rst) begin
                r_acc    <= '0;
                r_last   <= r_now;
                r_flt    <= 1'b0;
                r_reason <= FLT_NONE;
            end
            if (i_ctrl.flt_clr) begin
                r_flt    <= 1'b0;
                r_reason <= FLT_NONE;
            end
            if (i_ctrl.flt_chk) begin
                priority if (w_ov) begin
                    r_flt    <= 1'b1;
                    r_reason <= FLT_OVER_VOLT;
                end else if (w_ot) begin
                    r_flt    <= 1'b1;
                    r_reason <= FLT_OVER_TEMP;
                end else if (w_oc) begin
                    r_flt    <= 1'b1;
                    r_reason <= FLT_OVER_CUR;
                end
            end
            if (i_ctrl.out_wr) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_in) begin
            r_bus   <= i_bus_voltage_mv;
            r_cur   <= i_current_ma;
            r_temp  <= i_cell_temp;
            r_now   <= i_timestamp_ms;
            r_power <= '0;
            r_soc   <= '0;
            r_seg   <= '0;
        end
        if (i_ctrl.mul_en) begin
            r_prod <= w_mul_p;
            if (i_ctrl.mul_sel == MUL_ENERGY) begin
                r_pmag <= r_prod[PMAG_W-1:0];
            end
        end
        if (i_ctrl.power_wr) begin
            r_power <= w_neg ? (POWER_W'(0) - w_pq) : w_pq;
        end
        if (i_ctrl.energy_wr) begin
            r_energy <= r_acc[ACC_W-1] ? (ENERGY_W'(0) - w_eq) : w_eq;
        end
        if (i_ctrl.seg_last) begin
            r_seg <= SOC_IW'(SOC_POINTS - 1);
        end else if (i_ctrl.seg_mid) begin
            r_seg <= SOC_IW'(1);
        end else if (i_ctrl.seg_inc) begin
            r_seg <= r_seg + SOC_IW'(1);
        end
        if (i_ctrl.soc_const_wr) begin
            r_soc <= w_soc_cur;
        end else if (i_ctrl.soc_div_wr) begin
            r_soc <= w_soc_prev + w_quo[SOC_W-1:0];
        end
        if (i_ctrl.out_wr) begin
            r_o_power  <= r_power;
            r_o_energy <= r_energy;
            r_o_soc    <= r_soc;
            r_o_flt    <= r_flt;
            r_o_code   <= r_reason;
        end
    end

    always_comb begin
        o_stat.cmd      = r_cmd;
        o_stat.div_busy = w_div_busy;
        o_stat.seg_le   = w_bus_x <= w_vn_cur;
        o_stat.seg_ge   = w_bus_x >= w_vn_cur;
        o_stat.out_busy = r_out_valid && !i_out_ready;
    end

    assign o_out_valid    = r_out_valid;
    assign o_power_mw     = r_o_power;
    assign o_energy_mwh   = r_o_energy;
    assign o_soc_permille = r_o_soc;
    assign o_fault_active = r_o_flt;
    assign o_fault_code   = r_o_code;

endmodule

[src/bese_ctrl.sv]
// controller state machine sequencing one command through the datapath
`timescale 1ns / 1ps

module bese_ctrl
    import bese_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    t_state r_state;
    t_state n_state;
    logic   w_sample;

    assign w_sample = i_stat.cmd == CMD_SAMPLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:       if (i_in_valid) n_state = ST_CMD;
            ST_CMD:        n_state = w_sample ? ST_MUL_P : ST_EDIV_GO;
            ST_MUL_P:      n_state = ST_MUL_E;
            ST_MUL_E:      n_state = ST_ACC;
            ST_ACC:        n_state = ST_PDIV;
            ST_PDIV:       if (!i_stat.div_busy) n_state = ST_EDIV_GO;
            ST_EDIV_GO:    n_state = ST_EDIV;
            ST_EDIV: begin
                if (!i_stat.div_busy) begin
                    n_state = w_sample ? ST_SOC_FIRST : ST_OUT;
                end
            end
            ST_SOC_FIRST:  n_state = i_stat.seg_le ? ST_FAULT : ST_SOC_LAST;
            ST_SOC_LAST:   n_state = i_stat.seg_ge ? ST_FAULT : ST_SOC_SRCH;
            ST_SOC_SRCH:   if (i_stat.seg_le) n_state = ST_SOC_MUL;
            ST_SOC_MUL:    n_state = ST_SOC_DIV_GO;
            ST_SOC_DIV_GO: n_state = ST_SOC_DIV;
            ST_SOC_DIV:    if (!i_stat.div_busy) n_state = ST_FAULT;
            ST_FAULT:      n_state = ST_OUT;
            ST_OUT:        if (!i_stat.out_busy) n_state = ST_IDLE;
            default:       n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_ctrl.in_ready = 1'b1;
                o_ctrl.load_in  = i_in_valid;
            end
            ST_CMD: begin
                o_ctrl.sess_rst = i_stat.cmd == CMD_SESSION_RST;
                o_ctrl.flt_clr  = i_stat.cmd == CMD_FAULT_CLR;
            end
            ST_MUL_P: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mul_sel = MUL_POWER;
            end
            ST_MUL_E: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mul_sel = MUL_ENERGY;
            end
            ST_ACC: begin
                o_ctrl.acc_upd   = 1'b1;
                o_ctrl.div_start = 1'b1;
                o_ctrl.div_sel   = DIV_POWER;
            end
            ST_PDIV:       o_ctrl.power_wr = !i_stat.div_busy;
            ST_EDIV_GO: begin
                o_ctrl.div_start = 1'b1;
                o_ctrl.div_sel   = DIV_ENERGY;
            end
            ST_EDIV:       o_ctrl.energy_wr = !i_stat.div_busy;
            ST_SOC_FIRST: begin
                o_ctrl.soc_const_wr = i_stat.seg_le;
                o_ctrl.seg_last     = !i_stat.seg_le;
            end
            ST_SOC_LAST: begin
                o_ctrl.soc_const_wr = i_stat.seg_ge;
                o_ctrl.seg_mid      = !i_stat.seg_ge;
            end
            ST_SOC_SRCH:   o_ctrl.seg_inc = !i_stat.seg_le;
            ST_SOC_MUL: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mul_sel = MUL_SOC;
            end
            ST_SOC_DIV_GO: begin
                o_ctrl.div_start = 1'b1;
                o_ctrl.div_sel   = DIV_SOC;
            end
            ST_SOC_DIV:    o_ctrl.soc_div_wr = !i_stat.div_busy;
            ST_FAULT:      o_ctrl.flt_chk = 1'b1;
            ST_OUT:        o_ctrl.out_wr = !i_stat.out_busy;
            default:       o_ctrl = '0;
        endcase
    end

endmodule

[src/battery_energy_soc_fault_monitor.sv]
// top level of the battery energy, state-of-charge and fault monitor
`timescale 1ns / 1ps

// One command is worked on at a time. The shared divider produces two quotient bits per
// cycle and runs up to three times: for power, for energy and for the soc interpolation.
// The shared multiplier makes up to three passes. The soc segment search steps through the
// voltage table one point per cycle. A voltage clamped at either end of the table skips the
// search and its division. Reset-session, clear-fault and the spare command run only the
// energy division. The next command is accepted as soon as the result is in the output
// register, even while that result still waits to be taken. A result still waiting when the
// next one is ready holds the block.
module battery_energy_soc_fault_monitor
    import bese_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // bus_voltage_mv, current_ma, cell_temp, timestamp_ms, zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // command
    input  logic [CMD_W-1:0]       s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // power_mw, energy_mwh, soc_permille, fault_active, fault_code, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int CUR_LO  = BUS_W;
    localparam int TEMP_LO = CUR_LO + CUR_W;
    localparam int TS_LO   = TEMP_LO + TEMP_W;

    t_ctrl               w_ctrl;
    t_stat               w_stat;
    logic [POWER_W-1:0]  w_power;
    logic [ENERGY_W-1:0] w_energy;
    logic [SOC_W-1:0]    w_soc;
    logic                w_flt;
    logic [FCODE_W-1:0]  w_code;

    bese_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_stat     (w_stat),
        .o_ctrl     (w_ctrl)
    );

    bese_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctrl           (w_ctrl),
        .o_stat           (w_stat),
        .i_command        (s_axis_tuser),
        .i_bus_voltage_mv (s_axis_tdata[BUS_W-1:0]),
        .i_current_ma     (s_axis_tdata[TEMP_LO-1:CUR_LO]),
        .i_cell_temp      (s_axis_tdata[TS_LO-1:TEMP_LO]),
        .i_timestamp_ms   (s_axis_tdata[TS_LO+TS_W-1:TS_LO]),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_out_ready      (m_axis_tready),
        .o_out_valid      (m_axis_tvalid),
        .o_power_mw       (w_power),
        .o_energy_mwh     (w_energy),
        .o_soc_permille   (w_soc),
        .o_fault_active   (w_flt),
        .o_fault_code     (w_code)
    );

    assign s_axis_tready = w_ctrl.in_ready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, w_code, w_flt, w_soc, w_energy, w_power};

endmodule

[src/bese_chk.sv]
// port-level assertions for the battery energy monitor, bound to the top level
`timescale 1ns / 1ps

module bese_chk
    import bese_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int SOC_LO  = POWER_W + ENERGY_W;
    localparam int FLT_BIT = SOC_LO + SOC_W;
    localparam int CODE_LO = FLT_BIT + 1;

    // a waiting result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one command in flight: no transfer right after a transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready straight after a transfer");

    // flag and code move together
    a_flt_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
        (m_axis_tdata[FLT_BIT] == (m_axis_tdata[CODE_LO+FCODE_W-1:CODE_LO] != FLT_NONE)))
        else $error("fault flag and fault code disagree");

    // soc never above full
    a_soc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[FLT_BIT-1:SOC_LO] <= SOC_W'(1000))
        else $error("soc above 1000 permille");

endmodule

bind battery_energy_soc_fault_monitor bese_chk u_bese_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
